>>> rtl/dlswf_pkg.sv
// Shared constants, codes and types of the dirty list state write filter.
package dlswf_pkg;

    // Table sizes.
    localparam int NUM_PLAIN_STATES = 32;
    localparam int NUM_STAGES       = 4;
    localparam int NUM_TEX_TYPES    = 8;
    localparam int TEX_ENTRIES      = NUM_STAGES * NUM_TEX_TYPES;

    // Fixed port field widths.
    localparam int OP_W    = 2;
    localparam int INDEX_W = 5;
    localparam int STAGE_W = 2;
    localparam int TYPE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int KIND_W  = 2;

    // Entry address layout: {table, local}, where a texture local address is {stage, type}.
    localparam int PLAIN_AW   = (NUM_PLAIN_STATES > 1) ? $clog2(NUM_PLAIN_STATES) : 1;
    localparam int STAGE_BITS = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int TYPE_BITS  = (NUM_TEX_TYPES > 1) ? $clog2(NUM_TEX_TYPES) : 1;
    localparam int TEX_AW     = STAGE_BITS + TYPE_BITS;
    localparam int LOC_W      = (PLAIN_AW > TEX_AW) ? PLAIN_AW : TEX_AW;
    localparam int MEM_AW     = LOC_W + 1;
    localparam int MEM_DEPTH  = 2 ** MEM_AW;
    localparam int CNT_W      = LOC_W + 1;

    typedef logic [LOC_W-1:0]   loc_t;
    typedef logic [MEM_AW-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [STAGE_W-1:0] stage_t;
    typedef logic [TYPE_W-1:0]  ttype_t;

    localparam loc_t TYPE_MASK = loc_t'((1 << TYPE_BITS) - 1);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_SET_PLAIN = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_TEX   = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH     = 2'd2;

    // Result kinds.
    localparam kind_t KIND_NONE  = 2'd0;
    localparam kind_t KIND_PLAIN = 2'd1;
    localparam kind_t KIND_TEX   = 2'd2;

endpackage

>>> rtl/dlswf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dlswf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dirty_list_state_write_filter.sv
// Top level of the dirty list state write filter.
//
//   channel  | handshake            | words
//   ---------+----------------------+----------------------------------------------
//   command  | start high, busy low | op, state_index, stage, tex_type, value
//   result   | strobe, one cycle    | kind, out_index, out_stage, out_type,
//            |                      | out_value, last
//
// Set words are taken one per cycle while busy is low: a set reads the pending value
// in the cycle of its acceptance and compares and writes back in the next, with a
// forwarding register covering a set that hits the entry written just before it.
// A flush holds busy while it walks both lists: each list entry costs a list read,
// a pending/shadow read and a compare/write-back, all through the one read port
// of each RAM. Its last result is shown in the first cycle with busy low. After
// reset, busy stays high while the pending and shadow RAMs are swept to zero.
// The receiver cannot stall; each result is shown for exactly one cycle.
module dirty_list_state_write_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dlswf_pkg::OP_W-1:0]    op,
    input  logic [dlswf_pkg::INDEX_W-1:0] state_index,
    input  logic [dlswf_pkg::STAGE_W-1:0] stage,
    input  logic [dlswf_pkg::TYPE_W-1:0]  tex_type,
    input  logic [dlswf_pkg::VALUE_W-1:0] value,
    output logic                          strobe,
    output logic [dlswf_pkg::KIND_W-1:0]  kind,
    output logic [dlswf_pkg::INDEX_W-1:0] out_index,
    output logic [dlswf_pkg::STAGE_W-1:0] out_stage,
    output logic [dlswf_pkg::TYPE_W-1:0]  out_type,
    output logic [dlswf_pkg::VALUE_W-1:0] out_value,
    output logic                          last
);

    // Controller states.
    localparam logic [2:0] ST_CLEAR = 3'd0;  // sweeping RAMs to zero after reset
    localparam logic [2:0] ST_IDLE  = 3'd1;  // taking words
    localparam logic [2:0] ST_CHK   = 3'd2;  // next list entry, or next list
    localparam logic [2:0] ST_ADDR  = 3'd3;  // list entry back, read pending and shadow
    localparam logic [2:0] ST_CMP   = 3'd4;  // compare, update shadow, clear dirty mark
    localparam logic [2:0] ST_DONE  = 3'd5;  // deliver the final result

    logic [2:0] state_reg, state_next;

    // Clearing pass.
    dlswf_pkg::addr_t clr_reg, clr_next;

    // Set pipeline: second stage and forwarding of the last pending write.
    logic                s1_valid_reg, s1_valid_next;
    dlswf_pkg::addr_t    s1_addr_reg, s1_addr_next;
    dlswf_pkg::value_t   s1_value_reg, s1_value_next;
    logic                fwd_valid_reg, fwd_valid_next;
    dlswf_pkg::addr_t    fwd_addr_reg, fwd_addr_next;
    dlswf_pkg::value_t   fwd_value_reg, fwd_value_next;

    // List bookkeeping.
    logic [dlswf_pkg::MEM_DEPTH-1:0] dirty_reg, dirty_next;
    dlswf_pkg::cnt_t plain_count_reg, plain_count_next;
    dlswf_pkg::cnt_t tex_count_reg, tex_count_next;

    // Flush walk.
    logic              phase_reg, phase_next;   // 0 walks the plain list, 1 the texture list
    dlswf_pkg::cnt_t   idx_reg, idx_next;
    dlswf_pkg::loc_t   cur_loc_reg, cur_loc_next;

    // One found write is held back so that the final one can carry last.
    logic              held_valid_reg, held_valid_next;
    logic              held_tex_reg, held_tex_next;
    dlswf_pkg::loc_t   held_loc_reg, held_loc_next;
    dlswf_pkg::value_t held_value_reg, held_value_next;

    // Result register.
    logic                   strobe_reg, strobe_next;
    dlswf_pkg::kind_t       kind_reg, kind_next;
    dlswf_pkg::index_t      index_reg, index_next;
    dlswf_pkg::stage_t      stage_reg, stage_next;
    dlswf_pkg::ttype_t      type_reg, type_next;
    dlswf_pkg::value_t      value_reg, value_next;
    logic                   last_reg, last_next;

    // RAM ports.
    logic              pend_we, shad_we, list_we;
    dlswf_pkg::addr_t  pend_waddr, pend_raddr, shad_waddr, shad_raddr;
    dlswf_pkg::addr_t  list_waddr, list_raddr;
    dlswf_pkg::value_t pend_wdata, pend_rdata, shad_wdata, shad_rdata;
    dlswf_pkg::loc_t   list_wdata, list_rdata;

    // Command decode.
    logic              accept;
    logic              plain_ok, tex_ok, set_go, set_tex;
    dlswf_pkg::loc_t   set_loc;

    // Set stage two.
    dlswf_pkg::value_t old_value;
    logic              s1_change, s1_tex, s1_append;
    dlswf_pkg::cnt_t   s1_cnt, s1_limit;

    // Flush walk.
    dlswf_pkg::cnt_t   walk_count;
    logic              differ;

    // Emission.
    logic              emit_valid, emit_none, emit_tex, emit_last;
    dlswf_pkg::loc_t   emit_loc;
    dlswf_pkg::value_t emit_value;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign plain_ok = (32'(state_index) < dlswf_pkg::NUM_PLAIN_STATES);
    assign tex_ok   = (32'(stage) < dlswf_pkg::NUM_STAGES)
                   && (32'(tex_type) < dlswf_pkg::NUM_TEX_TYPES);
    assign set_tex  = (op == dlswf_pkg::OP_SET_TEX);
    assign set_go   = accept && (((op == dlswf_pkg::OP_SET_PLAIN) && plain_ok)
                              || (set_tex && tex_ok));
    assign set_loc  = set_tex
                    ? ((dlswf_pkg::loc_t'(stage) << dlswf_pkg::TYPE_BITS)
                       | dlswf_pkg::loc_t'(tex_type))
                    : dlswf_pkg::loc_t'(state_index);

    // Pending value seen by the set in stage two; the RAM returns the
    // old contents if the previous set wrote this entry on the same edge.
    assign old_value = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
                     ? fwd_value_reg : pend_rdata;
    assign s1_change = s1_valid_reg && (old_value != s1_value_reg);
    assign s1_tex    = s1_addr_reg[dlswf_pkg::MEM_AW-1];
    assign s1_cnt    = s1_tex ? tex_count_reg : plain_count_reg;
    assign s1_limit  = s1_tex ? dlswf_pkg::cnt_t'(dlswf_pkg::TEX_ENTRIES)
                              : dlswf_pkg::cnt_t'(dlswf_pkg::NUM_PLAIN_STATES);
    assign s1_append = s1_change && !dirty_reg[s1_addr_reg] && (s1_cnt < s1_limit);

    assign walk_count = phase_reg ? tex_count_reg : plain_count_reg;
    assign differ     = (pend_rdata != shad_rdata);

    // RAM port steering.
    always_comb
    begin
        pend_raddr = (state_reg == ST_ADDR) ? {phase_reg, list_rdata} : {set_tex, set_loc};
        shad_raddr = {phase_reg, list_rdata};
        list_raddr = {phase_reg, idx_reg[dlswf_pkg::LOC_W-1:0]};

        if (state_reg == ST_CLEAR)
        begin
            pend_we    = 1'b1;
            pend_waddr = clr_reg;
            pend_wdata = '0;
            shad_we    = 1'b1;
            shad_waddr = clr_reg;
            shad_wdata = '0;
        end
        else
        begin
            pend_we    = s1_change;
            pend_waddr = s1_addr_reg;
            pend_wdata = s1_value_reg;
            shad_we    = (state_reg == ST_CMP) && differ;
            shad_waddr = {phase_reg, cur_loc_reg};
            shad_wdata = pend_rdata;
        end

        list_we    = s1_append;
        list_waddr = {s1_tex, s1_cnt[dlswf_pkg::LOC_W-1:0]};
        list_wdata = s1_addr_reg[dlswf_pkg::LOC_W-1:0];
    end

    // Controller and bookkeeping.
    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        s1_valid_next    = set_go;
        s1_addr_next     = {set_tex, set_loc};
        s1_value_next    = value;
        fwd_valid_next   = pend_we && (state_reg != ST_CLEAR);
        fwd_addr_next    = s1_addr_reg;
        fwd_value_next   = s1_value_reg;
        dirty_next       = dirty_reg;
        plain_count_next = plain_count_reg;
        tex_count_next   = tex_count_reg;
        phase_next       = phase_reg;
        idx_next         = idx_reg;
        cur_loc_next     = cur_loc_reg;
        held_valid_next  = held_valid_reg;
        held_tex_next    = held_tex_reg;
        held_loc_next    = held_loc_reg;
        held_value_next  = held_value_reg;
        emit_valid       = 1'b0;
        emit_none        = 1'b0;
        emit_last        = 1'b0;
        emit_tex         = held_tex_reg;
        emit_loc         = held_loc_reg;
        emit_value       = held_value_reg;

        // First change of an entry since the last flush puts it on its list.
        if (s1_append)
        begin
            dirty_next[s1_addr_reg] = 1'b1;
            if (s1_tex)
            begin
                tex_count_next = tex_count_reg + 1'b1;
            end
            else
            begin
                plain_count_next = plain_count_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (op == dlswf_pkg::OP_FLUSH))
                begin
                    state_next      = ST_CHK;
                    phase_next      = 1'b0;
                    idx_next        = '0;
                    held_valid_next = 1'b0;
                end
            end
            ST_CHK:
            begin
                if (idx_reg < walk_count)
                begin
                    state_next = ST_ADDR;
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ADDR:
            begin
                cur_loc_next = list_rdata;
                state_next   = ST_CMP;
            end
            ST_CMP:
            begin
                dirty_next[{phase_reg, cur_loc_reg}] = 1'b0;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_CHK;
                if (differ)
                begin
                    // Deliver the one held so far and hold this one.
                    emit_valid      = held_valid_reg;
                    held_valid_next = 1'b1;
                    held_tex_next   = phase_reg;
                    held_loc_next   = cur_loc_reg;
                    held_value_next = pend_rdata;
                end
            end
            ST_DONE:
            begin
                emit_valid       = 1'b1;
                emit_none        = !held_valid_reg;
                emit_last        = 1'b1;
                held_valid_next  = 1'b0;
                plain_count_next = '0;
                tex_count_next   = '0;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result word formatting.
    always_comb
    begin
        strobe_next = emit_valid;
        last_next   = emit_last;
        kind_next   = dlswf_pkg::KIND_NONE;
        index_next  = '0;
        stage_next  = '0;
        type_next   = '0;
        value_next  = '0;
        if (!emit_none)
        begin
            value_next = emit_value;
            if (emit_tex)
            begin
                kind_next  = dlswf_pkg::KIND_TEX;
                stage_next = dlswf_pkg::stage_t'(emit_loc >> dlswf_pkg::TYPE_BITS);
                type_next  = dlswf_pkg::ttype_t'(emit_loc & dlswf_pkg::TYPE_MASK);
            end
            else
            begin
                kind_next  = dlswf_pkg::KIND_PLAIN;
                index_next = dlswf_pkg::index_t'(emit_loc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            dirty_reg       <= '0;
            plain_count_reg <= '0;
            tex_count_reg   <= '0;
            phase_reg       <= 1'b0;
            idx_reg         <= '0;
            held_valid_reg  <= 1'b0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            s1_valid_reg    <= s1_valid_next;
            fwd_valid_reg   <= fwd_valid_next;
            dirty_reg       <= dirty_next;
            plain_count_reg <= plain_count_next;
            tex_count_reg   <= tex_count_next;
            phase_reg       <= phase_next;
            idx_reg         <= idx_next;
            held_valid_reg  <= held_valid_next;
            strobe_reg      <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg    <= s1_addr_next;
        s1_value_reg   <= s1_value_next;
        fwd_addr_reg   <= fwd_addr_next;
        fwd_value_reg  <= fwd_value_next;
        cur_loc_reg    <= cur_loc_next;
        held_tex_reg   <= held_tex_next;
        held_loc_reg   <= held_loc_next;
        held_value_reg <= held_value_next;
        kind_reg       <= kind_next;
        index_reg      <= index_next;
        stage_reg      <= stage_next;
        type_reg       <= type_next;
        value_reg      <= value_next;
        last_reg       <= last_next;
    end

    // Pending values of both tables, addressed {table, local}.
    dlswf_ram #(
        .WIDTH (dlswf_pkg::VALUE_W),
        .DEPTH (dlswf_pkg::MEM_DEPTH)
    ) u_pending (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

    // Shadow of what the device holds.
    dlswf_ram #(
        .WIDTH (dlswf_pkg::VALUE_W),
        .DEPTH (dlswf_pkg::MEM_DEPTH)
    ) u_shadow (
        .clk   (clk),
        .we    (shad_we),
        .waddr (shad_waddr),
        .wdata (shad_wdata),
        .raddr (shad_raddr),
        .rdata (shad_rdata)
    );

    // Dirty lists: the plain list in the lower half, the texture list in the upper.
    dlswf_ram #(
        .WIDTH (dlswf_pkg::LOC_W),
        .DEPTH (dlswf_pkg::MEM_DEPTH)
    ) u_list (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    assign strobe    = strobe_reg;
    assign kind      = kind_reg;
    assign out_index = index_reg;
    assign out_stage = stage_reg;
    assign out_type  = type_reg;
    assign out_value = value_reg;
    assign last      = last_reg;

endmodule

>>> rtl/dlswf_checker.sv
// Port-level checker of the dirty list state write filter and its bind.
module dlswf_assertions (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [dlswf_pkg::OP_W-1:0]    op,
    input logic                          strobe,
    input logic [dlswf_pkg::KIND_W-1:0]  kind,
    input logic [dlswf_pkg::VALUE_W-1:0] out_value,
    input logic                          last
);

    // An empty flush gives a single zero word that ends the flush.
    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == dlswf_pkg::KIND_NONE) |-> last && (out_value == '0))
        else $error("empty-flush word malformed");

    // Words before the final one come while the flush still runs.
    a_mid_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("non-final word outside a flush");

    // The final word of a flush is never followed straight away by another.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("word right after the end of a flush");

    // A flush makes the block busy.
    a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (op == dlswf_pkg::OP_FLUSH) |=> busy)
        else $error("flush taken without going busy");

endmodule

bind dirty_list_state_write_filter dlswf_assertions u_dlswf_assertions (.*);

>>> verif/dlswf_checker.sv
// Checker for the dirty list state write filter: predicts device writes and compares results.
`timescale 1ns / 100ps

module dlswf_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [dlswf_pkg::OP_W-1:0]    op,
    input  logic [dlswf_pkg::INDEX_W-1:0] state_index,
    input  logic [dlswf_pkg::STAGE_W-1:0] stage,
    input  logic [dlswf_pkg::TYPE_W-1:0]  tex_type,
    input  logic [dlswf_pkg::VALUE_W-1:0] value,
    input  logic                          strobe,
    input  logic [dlswf_pkg::KIND_W-1:0]  kind,
    input  logic [dlswf_pkg::INDEX_W-1:0] out_index,
    input  logic [dlswf_pkg::STAGE_W-1:0] out_stage,
    input  logic [dlswf_pkg::TYPE_W-1:0]  out_type,
    input  logic [dlswf_pkg::VALUE_W-1:0] out_value,
    input  logic                          last,
    output int                            errors,
    output int                            outstanding
);

    import dlswf_pkg::*;

    typedef struct packed {
        kind_t  kind;
        index_t idx;
        stage_t stg;
        ttype_t typ;
        value_t val;
        logic   fin;
    } dev_write_t;

    dev_write_t expected_writes[$];

    // Own copy of the pending values, dirty marks, device shadows and dirty lists.
    bit [VALUE_W-1:0] plain_pending [NUM_PLAIN_STATES];
    bit [VALUE_W-1:0] plain_shadow  [NUM_PLAIN_STATES];
    bit               plain_dirty   [NUM_PLAIN_STATES];
    int               plain_order[$];
    bit [VALUE_W-1:0] tex_pending [TEX_ENTRIES];
    bit [VALUE_W-1:0] tex_shadow  [TEX_ENTRIES];
    bit               tex_dirty   [TEX_ENTRIES];
    int               tex_order[$];

    int error_count   = 0;
    int pending_count = 0;

    assign errors      = error_count;
    assign outstanding = pending_count;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
        end
    endtask

    // Walks both dirty lists in order of first change and queues the writes a flush makes.
    function automatic void drain_dirty_lists();
        dev_write_t batch[$];
        dev_write_t w;
        int         s;
        int         e;
        foreach (plain_order[i])
        begin
            s = plain_order[i];
            plain_dirty[s] = 1'b0;
            if (plain_shadow[s] != plain_pending[s])
            begin
                w      = '0;
                w.kind = KIND_PLAIN;
                w.idx  = index_t'(s);
                w.val  = plain_pending[s];
                batch.push_back(w);
                plain_shadow[s] = plain_pending[s];
            end
        end
        plain_order.delete();
        foreach (tex_order[i])
        begin
            e = tex_order[i];
            tex_dirty[e] = 1'b0;
            if (tex_shadow[e] != tex_pending[e])
            begin
                w      = '0;
                w.kind = KIND_TEX;
                w.stg  = stage_t'(e / NUM_TEX_TYPES);
                w.typ  = ttype_t'(e % NUM_TEX_TYPES);
                w.val  = tex_pending[e];
                batch.push_back(w);
                tex_shadow[e] = tex_pending[e];
            end
        end
        tex_order.delete();
        if (batch.size() == 0)
        begin
            w      = '0;
            w.kind = KIND_NONE;
            batch.push_back(w);
        end
        w     = batch.pop_back();
        w.fin = 1'b1;
        batch.push_back(w);
        foreach (batch[i])
        begin
            expected_writes.push_back(batch[i]);
        end
    endfunction

    function automatic void apply_command(input logic [OP_W-1:0] c_op, input index_t c_idx,
                                          input stage_t c_stg, input ttype_t c_typ,
                                          input value_t c_val);
        int e;
        case (c_op)
            OP_SET_PLAIN:
            begin
                if (c_idx < NUM_PLAIN_STATES && plain_pending[c_idx] != c_val)
                begin
                    plain_pending[c_idx] = c_val;
                    if (!plain_dirty[c_idx])
                    begin
                        plain_dirty[c_idx] = 1'b1;
                        plain_order.push_back(int'(c_idx));
                    end
                end
            end
            OP_SET_TEX:
            begin
                if (c_stg < NUM_STAGES && c_typ < NUM_TEX_TYPES)
                begin
                    e = int'(c_stg) * NUM_TEX_TYPES + int'(c_typ);
                    if (tex_pending[e] != c_val)
                    begin
                        tex_pending[e] = c_val;
                        if (!tex_dirty[e])
                        begin
                            tex_dirty[e] = 1'b1;
                            tex_order.push_back(e);
                        end
                    end
                end
            end
            OP_FLUSH:
            begin
                drain_dirty_lists();
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        dev_write_t want;
        if (rst_n === 1'b1)
        begin
            if (strobe === 1'b1)
            begin
                if (expected_writes.size() == 0)
                begin
                    report_mismatch($sformatf("result kind %h value %h with none expected",
                                              kind, out_value));
                end
                else
                begin
                    want = expected_writes.pop_front();
                    check_field("kind", 32'(kind), 32'(want.kind));
                    check_field("out_index", 32'(out_index), 32'(want.idx));
                    check_field("out_stage", 32'(out_stage), 32'(want.stg));
                    check_field("out_type", 32'(out_type), 32'(want.typ));
                    check_field("out_value", out_value, want.val);
                    check_field("last", 32'(last), 32'(want.fin));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                apply_command(op, state_index, stage, tex_type, value);
            end
            pending_count <= expected_writes.size();
        end
    end

endmodule

>>> verif/testbench.sv
// Top of the testbench: clock, reset and command stimulus for the state write filter.
`timescale 1ns / 100ps

module testbench;

    import dlswf_pkg::*;

    // The op code the block must ignore; it has no name in the package.
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    // The random part stops once this many set and flush words have gone in.
    localparam int ITEM_TARGET = 180;

    // Even a run made only of full flushes of both lists with every gap, after the
    // reset sweep, stays far below this.
    localparam int CYCLE_LIMIT = 200000;

    bit                   clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [OP_W-1:0]      op;
    logic [INDEX_W-1:0]   state_index;
    logic [STAGE_W-1:0]   stage;
    logic [TYPE_W-1:0]    tex_type;
    logic [VALUE_W-1:0]   value;
    logic                 strobe;
    logic [KIND_W-1:0]    kind;
    logic [INDEX_W-1:0]   out_index;
    logic [STAGE_W-1:0]   out_stage;
    logic [TYPE_W-1:0]    out_type;
    logic [VALUE_W-1:0]   out_value;
    logic                 last;

    int errors;
    int outstanding;
    int items  = 0;
    int cycles = 0;

    always #5 clk = ~clk;

    dirty_list_state_write_filter u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .state_index (state_index),
        .stage       (stage),
        .tex_type    (tex_type),
        .value       (value),
        .strobe      (strobe),
        .kind        (kind),
        .out_index   (out_index),
        .out_stage   (out_stage),
        .out_type    (out_type),
        .out_value   (out_value),
        .last        (last)
    );

    // The checker sits beside the block, watching both channels; it predicts every
    // device write and hands back its mismatch count and the number still awaited.
    dlswf_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .state_index (state_index),
        .stage       (stage),
        .tex_type    (tex_type),
        .value       (value),
        .strobe      (strobe),
        .kind        (kind),
        .out_index   (out_index),
        .out_stage   (out_stage),
        .out_type    (out_type),
        .out_value   (out_value),
        .last        (last),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Values are drawn so that many sets repeat the pending value or move an
    // entry back to what the device already holds.
    function automatic value_t pick_value();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return value_t'($urandom_range(0, 3));
            default: return value_t'($urandom);
        endcase
    endfunction

    // Half of the indexes come from a small hot set, so back-to-back sets often hit
    // the same entry and exercise the forwarding path.
    function automatic index_t pick_index();
        if ($urandom_range(0, 1))
            return index_t'($urandom_range(0, NUM_PLAIN_STATES - 1));
        return index_t'($urandom_range(0, 3));
    endfunction

    function automatic ttype_t pick_type();
        if ($urandom_range(0, 1))
            return ttype_t'($urandom_range(0, NUM_TEX_TYPES - 1));
        return ttype_t'($urandom_range(0, 1));
    endfunction

    // Idle cycles drop start and scramble op, state_index and value, which the block must ignore.
    task automatic idle_for(input int n);
        repeat (n) begin
            @(negedge clk);
            start       <= 1'b0;
            op          <= OP_W'($urandom);
            state_index <= INDEX_W'($urandom);
            value       <= value_t'($urandom);
        end
    endtask

    // Presents one command word from a falling edge and holds it until a rising edge
    // sees busy low. Outside the quiet window about one word in ten is preceded by
    // a short gap, so gaps land both while a flush runs and while the block is free.
    task automatic send_word(input logic [OP_W-1:0] w_op, input index_t w_idx,
                             input stage_t w_stg, input ttype_t w_typ, input value_t w_val);
        if (!(items >= 70 && items < 120) && $urandom_range(0, 99) < 10)
            idle_for($urandom_range(1, 5));
        @(negedge clk);
        start       <= 1'b1;
        op          <= w_op;
        state_index <= w_idx;
        stage       <= w_stg;
        tex_type    <= w_typ;
        value       <= w_val;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (w_op != OP_RESERVED)
            items++;
    endtask

    // Fields that an op does not use carry random junk.
    task automatic set_plain(input index_t idx, input value_t val);
        send_word(OP_SET_PLAIN, idx, stage_t'($urandom), ttype_t'($urandom), val);
    endtask

    task automatic set_tex(input stage_t stg, input ttype_t typ, input value_t val);
        send_word(OP_SET_TEX, index_t'($urandom), stg, typ, val);
    endtask

    task automatic flush_lists();
        send_word(OP_FLUSH, index_t'($urandom), stage_t'($urandom), ttype_t'($urandom),
                  value_t'($urandom));
    endtask

    initial begin
        int pick;
        int n;
        bit swept;

        swept       = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        op          = '0;
        state_index = '0;
        stage       = '0;
        tex_type    = '0;
        value       = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A flush with nothing dirty gives the single empty result.
        flush_lists();
        // Sets that repeat the reset value change nothing, so the flush is empty again.
        set_plain(index_t'(0), '0);
        set_tex(stage_t'(0), ttype_t'(0), '0);
        flush_lists();
        // Extremes of index, stage, type and value; a second change to an entry that
        // is already dirty must not append it twice, and a repeated value is no change.
        set_plain(index_t'(NUM_PLAIN_STATES - 1), '1);
        set_plain(index_t'(0), value_t'(1));
        set_plain(index_t'(NUM_PLAIN_STATES - 1), value_t'(5));
        set_tex(stage_t'(NUM_STAGES - 1), ttype_t'(NUM_TEX_TYPES - 1), '1);
        set_tex(stage_t'(0), ttype_t'(0), 32'h8000_0000);
        set_tex(stage_t'(NUM_STAGES - 1), ttype_t'(NUM_TEX_TYPES - 1), '1);
        // The reserved op is ignored.
        send_word(OP_RESERVED, '1, '1, '1, '1);
        flush_lists();
        // Entries that are dirty but end up back at the device value write nothing.
        set_plain(index_t'(5), value_t'(7));
        set_plain(index_t'(5), '0);
        set_tex(stage_t'(1), ttype_t'(2), 32'hAAAA_5555);
        set_tex(stage_t'(1), ttype_t'(2), '0);
        flush_lists();
        // Mixed: one entry returns to its shadow, two others really change.
        set_plain(index_t'(0), value_t'(1));
        set_plain(index_t'(0), value_t'(2));
        set_plain(index_t'(0), value_t'(1));
        set_plain(index_t'(16), 32'h1234_5678);
        set_tex(stage_t'(2), ttype_t'(4), 32'h55AA_55AA);
        flush_lists();

        // Random part: mostly bursts of sets closed by a flush, at most once a sweep over
        // every entry of both tables for the longest flush, and some noise.
        while (items < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (!swept && pick < 6) begin
                swept = 1'b1;
                for (int s = 0; s < NUM_PLAIN_STATES; s++)
                    set_plain(index_t'(s), value_t'($urandom));
                for (int st = 0; st < NUM_STAGES; st++)
                    for (int ty = 0; ty < NUM_TEX_TYPES; ty++)
                        set_tex(stage_t'(st), ttype_t'(ty), value_t'($urandom));
                flush_lists();
            end else if (pick < 85) begin
                n = $urandom_range(1, 10);
                repeat (n) begin
                    if ($urandom_range(0, 1))
                        set_plain(pick_index(), pick_value());
                    else
                        set_tex(stage_t'($urandom), pick_type(), pick_value());
                end
                // Now and then the burst runs on into the next one without a flush.
                if ($urandom_range(0, 4) != 0)
                    flush_lists();
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 3))
                    send_word(OP_RESERVED, index_t'($urandom), stage_t'($urandom),
                              ttype_t'($urandom), value_t'($urandom));
            end else begin
                flush_lists();
            end
        end

        @(negedge clk);
        start <= 1'b0;

        // Wait for every predicted write, then a while longer to catch strays.
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
